[hw/rtl/bwg_pkg.sv]
`timescale 1ns / 1ps

package bwg_pkg;

   // Fixed-point format and grid limits
   localparam int FRAC_BITS = 16;
   localparam int GRID_SIZE = 1024;
   localparam int ONE_Q     = 2 ** FRAC_BITS;

   // Field widths
   localparam int NODE_W = 10;
   localparam int POS_W  = 32;
   localparam int INV_W  = 24;
   localparam int OUT_W  = 25;

   // Stream data widths, padded to whole bytes
   localparam int REQ_FIELDS_W = 2 * NODE_W + 2 * POS_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * OUT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Internal datapath widths
   localparam int PROD_W = POS_W + INV_W + 1;       // pos * inv, exact
   localparam int D_W    = PROD_W - FRAC_BITS;      // offset d in Q.F
   localparam int X_W    = FRAC_BITS + 1;           // a or 2-a
   localparam int X2_W   = FRAC_BITS + 2;           // x^2 in Q.F
   localparam int X3_W   = FRAC_BITS + 3;           // x^3 in Q.F
   localparam int NUM_W  = FRAC_BITS + 7;           // weight numerator, signed
   localparam int SL_W   = FRAC_BITS + 6;           // slope before trimming, signed
   localparam int DW_W   = FRAC_BITS + 3;           // N'(d), signed
   localparam int W_W    = FRAC_BITS + 1;           // N(d), unsigned
   localparam int T_W    = DW_W + INV_W + 1 - FRAC_BITS;
   localparam int G_W    = T_W + W_W + 1 - FRAC_BITS;

   // floor(n / 6) as floor((n >> 1) * M / 2^K)
   localparam int DIV3_SHIFT = FRAC_BITS + 5;
   localparam int DIV3_MULT  = (2 ** DIV3_SHIFT + 2) / 3;

   // Pipeline depth
   localparam int AXIS_STAGES = 7;
   localparam int GRAD_STAGES = 2;
   localparam int STAGES      = AXIS_STAGES + GRAD_STAGES;

   typedef logic [STAGES-1:0] stage_en_type;

   // Per-axis kernel result
   typedef struct packed {
      logic [W_W-1:0]         w;
      logic signed [DW_W-1:0] dw;
   } axis_res_type;

endpackage

[hw/rtl/bwg_ctrl.sv]
`timescale 1ns / 1ps

module bwg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output bwg_pkg::stage_en_type stage_en
);
   import bwg_pkg::*;

   stage_en_type valid_ff;
   stage_en_type valid_in;
   stage_en_type valid_src;

   // A stage moves when it is empty or the stage after it moves
   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   // Valid bits shift along with the data
   assign valid_src = {valid_ff[STAGES-2:0], req_tvalid};
   assign valid_in  = (stage_en & valid_src) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

endmodule

[hw/rtl/bwg_axis.sv]
`timescale 1ns / 1ps

module bwg_axis (
   input  logic                               clock,
   input  logic [bwg_pkg::AXIS_STAGES-1:0]    stage_en,
   input  logic [bwg_pkg::NODE_W-1:0]         node,
   input  logic signed [bwg_pkg::POS_W-1:0]   pos,
   input  logic [bwg_pkg::INV_W-1:0]          inv_spacing,
   output bwg_pkg::axis_res_type              res
);
   import bwg_pkg::*;

   localparam int Q_W = (NUM_W - 2) + (DIV3_SHIFT - 1);

   // Stage 1: pos * inv
   logic signed [PROD_W-1:0] prod_1_ff;
   logic [NODE_W-1:0]        node_1_ff;
   logic                     oog_1_ff;

   // Stage 2: offset d
   logic signed [D_W-1:0]    d_2_ff;
   logic                     oog_2_ff;

   // Stage 3: |d|, region, x
   logic [D_W-1:0]           abs_d;
   logic                     far;
   logic                     inner;
   logic [X_W:0]             b_full;
   logic [X_W-1:0]           x_in;
   logic [X_W-1:0]           x_3_ff;
   logic                     neg_3_ff;
   logic                     inner_3_ff;
   logic                     zero_3_ff;

   // Stage 4: x^2
   logic [2*X_W-1:0]         sq;
   logic [X2_W-1:0]          x2_4_ff;
   logic [X_W-1:0]           x_4_ff;
   logic                     neg_4_ff;
   logic                     inner_4_ff;
   logic                     zero_4_ff;

   // Stage 5: x^3
   logic [X2_W+X_W-1:0]      cu;
   logic [X3_W-1:0]          x3_5_ff;
   logic [X2_W-1:0]          x2_5_ff;
   logic [X_W-1:0]           x_5_ff;
   logic                     neg_5_ff;
   logic                     inner_5_ff;
   logic                     zero_5_ff;

   // Stage 6: weight numerator and slope
   logic signed [NUM_W-1:0]  x2_n;
   logic signed [NUM_W-1:0]  x3_n;
   logic signed [NUM_W-1:0]  num_i;
   logic [NUM_W-2:0]         num_in;
   logic signed [SL_W-1:0]   sx;
   logic signed [SL_W-1:0]   sx2;
   logic signed [SL_W-1:0]   sl_inner;
   logic signed [SL_W-1:0]   sl_outer;
   logic signed [SL_W-1:0]   sl_mag;
   logic signed [SL_W-1:0]   sl_in;
   logic [NUM_W-2:0]         num_6_ff;
   logic signed [DW_W-1:0]   dw_6_ff;

   // Stage 7: divide by six
   logic [DIV3_SHIFT-2:0]    div3_m;
   logic [Q_W-1:0]           q;
   logic [W_W-1:0]           w_7_ff;
   logic signed [DW_W-1:0]   dw_7_ff;

   // Stage 1
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_1_ff <= pos * $signed({1'b0, inv_spacing});
         node_1_ff <= node;
         oog_1_ff  <= (32'(node) >= 32'(GRID_SIZE));
      end
   end

   // Stage 2: d = floor(pos*inv / 2^F) - node*2^F
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         d_2_ff   <= $signed(prod_1_ff[PROD_W-1:FRAC_BITS])
                     - $signed(D_W'({node_1_ff, {FRAC_BITS{1'b0}}}));
         oog_2_ff <= oog_1_ff;
      end
   end

   // Stage 3: magnitude, region and x = a or 2 - a
   always_comb begin
      abs_d  = d_2_ff[D_W-1] ? D_W'(-d_2_ff) : D_W'(d_2_ff);
      far    = |abs_d[D_W-1:FRAC_BITS+1];
      inner  = ~|abs_d[D_W-1:FRAC_BITS];
      b_full = (X_W+1)'(2 * ONE_Q) - {1'b0, abs_d[X_W-1:0]};
      x_in   = inner ? abs_d[X_W-1:0] : b_full[X_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         x_3_ff     <= x_in;
         neg_3_ff   <= d_2_ff[D_W-1];
         inner_3_ff <= inner;
         zero_3_ff  <= far || oog_2_ff;
      end
   end

   // Stage 4: x2 = floor(x*x / 2^F)
   assign sq = (2*X_W)'(x_3_ff) * (2*X_W)'(x_3_ff);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         x2_4_ff    <= sq[2*X_W-1:FRAC_BITS];
         x_4_ff     <= x_3_ff;
         neg_4_ff   <= neg_3_ff;
         inner_4_ff <= inner_3_ff;
         zero_4_ff  <= zero_3_ff;
      end
   end

   // Stage 5: x3 = floor(x2*x / 2^F)
   assign cu = (X2_W+X_W)'(x2_4_ff) * (X2_W+X_W)'(x_4_ff);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         x3_5_ff    <= cu[X2_W+X_W-1:FRAC_BITS];
         x2_5_ff    <= x2_4_ff;
         x_5_ff     <= x_4_ff;
         neg_5_ff   <= neg_4_ff;
         inner_5_ff <= inner_4_ff;
         zero_5_ff  <= zero_4_ff;
      end
   end

   // Stage 6: inner numerator 3*a3 - 6*a2 + 4, clamped; outer numerator b3.
   // Slope: inner (3*a2 - 4*a)/2, outer -b2/2, odd in d.
   always_comb begin
      x2_n     = NUM_W'(x2_5_ff);
      x3_n     = NUM_W'(x3_5_ff);
      num_i    = (x3_n <<< 1) + x3_n - (x2_n <<< 2) - (x2_n <<< 1)
                 + NUM_W'(4 * ONE_Q);
      if (zero_5_ff) begin
         num_in = '0;
      end else if (inner_5_ff) begin
         num_in = num_i[NUM_W-1] ? '0 : num_i[NUM_W-2:0];
      end else begin
         num_in = (NUM_W-1)'(x3_5_ff);
      end

      sx       = SL_W'(x_5_ff);
      sx2      = SL_W'(x2_5_ff);
      sl_inner = ((sx2 <<< 1) + sx2 - (sx <<< 2)) >>> 1;
      sl_outer = -(sx2 >>> 1);
      sl_mag   = inner_5_ff ? sl_inner : sl_outer;
      if (zero_5_ff) begin
         sl_in = '0;
      end else begin
         sl_in = neg_5_ff ? -sl_mag : sl_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         num_6_ff <= num_in;
         dw_6_ff  <= sl_in[DW_W-1:0];
      end
   end

   // Stage 7: floor(num / 6) by reciprocal multiply
   assign div3_m = (DIV3_SHIFT-1)'(DIV3_MULT);
   assign q      = Q_W'(num_6_ff[NUM_W-2:1]) * Q_W'(div3_m);

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         w_7_ff  <= q[DIV3_SHIFT+W_W-1:DIV3_SHIFT];
         dw_7_ff <= dw_6_ff;
      end
   end

   assign res.w  = w_7_ff;
   assign res.dw = dw_7_ff;

endmodule

[hw/rtl/bwg_grad.sv]
`timescale 1ns / 1ps

module bwg_grad (
   input  logic                              clock,
   input  logic [bwg_pkg::GRAD_STAGES-1:0]   stage_en,
   input  logic [bwg_pkg::INV_W-1:0]         inv_spacing,
   input  bwg_pkg::axis_res_type             res_x,
   input  bwg_pkg::axis_res_type             res_y,
   output logic signed [bwg_pkg::OUT_W-1:0]  grad_x,
   output logic signed [bwg_pkg::OUT_W-1:0]  grad_y
);
   import bwg_pkg::*;

   localparam int TP_W = DW_W + INV_W + 1;
   localparam int GP_W = T_W + W_W + 1;

   // Clamp to the output range
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [G_W-1:0] g);
      logic fits;
      fits = (g[G_W-1:OUT_W-1] == '0) || (g[G_W-1:OUT_W-1] == '1);
      if (fits) begin
         sat_out = g[OUT_W-1:0];
      end else if (g[G_W-1]) begin
         sat_out = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_out = {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   logic signed [TP_W-1:0] tp_x;
   logic signed [TP_W-1:0] tp_y;
   logic signed [T_W-1:0]  t_x_ff;
   logic signed [T_W-1:0]  t_y_ff;
   logic [W_W-1:0]         w_x_ff;
   logic [W_W-1:0]         w_y_ff;
   logic signed [GP_W-1:0] gp_x;
   logic signed [GP_W-1:0] gp_y;
   logic signed [OUT_W-1:0] grad_x_ff;
   logic signed [OUT_W-1:0] grad_y_ff;

   // Stage 8: t = floor(N' * inv / 2^F)
   assign tp_x = res_x.dw * $signed({1'b0, inv_spacing});
   assign tp_y = res_y.dw * $signed({1'b0, inv_spacing});

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         t_x_ff <= tp_x[TP_W-1:FRAC_BITS];
         t_y_ff <= tp_y[TP_W-1:FRAC_BITS];
         w_x_ff <= res_x.w;
         w_y_ff <= res_y.w;
      end
   end

   // Stage 9: g = floor(t * N(other axis) / 2^F), saturated
   assign gp_x = t_x_ff * $signed({1'b0, w_y_ff});
   assign gp_y = t_y_ff * $signed({1'b0, w_x_ff});

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         grad_x_ff <= sat_out(gp_x[GP_W-1:FRAC_BITS]);
         grad_y_ff <= sat_out(gp_y[GP_W-1:FRAC_BITS]);
      end
   end

   assign grad_x = grad_x_ff;
   assign grad_y = grad_y_ff;

endmodule

[hw/rtl/bspline_weight_gradient_2d.sv]
// Cubic B-spline weight gradient, 2D, for particle/node pairs.
// Pipeline: nine register stages, the last of which holds the result.
// Throughput: one request per cycle unless stalled, set by the fully pipelined multipliers.
// Stalls hold each full stage in place; empty stages are filled while the output waits.
// Reset (synchronous): all stages empty, inv_spacing back to 1.0 (0x010000).
`timescale 1ns / 1ps

module bspline_weight_gradient_2d (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration
   input  logic                               csr_wr_en,
   input  logic [bwg_pkg::INV_W-1:0]          csr_wr_data,  // inv_spacing, unsigned Q8.16
   // Requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bwg_pkg::REQ_DATA_W-1:0]     req_tdata,    // node_x, node_y, pos_x, pos_y
   // Results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bwg_pkg::RSP_DATA_W-1:0]     rsp_tdata     // grad_x, grad_y
);
   import bwg_pkg::*;

   logic [INV_W-1:0]        inv_ff;
   logic [INV_W-1:0]        inv_in;
   stage_en_type            stage_en;
   logic [NODE_W-1:0]       node_x;
   logic [NODE_W-1:0]       node_y;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   axis_res_type            res_x;
   axis_res_type            res_y;
   logic signed [OUT_W-1:0] grad_x;
   logic signed [OUT_W-1:0] grad_y;

   // Spacing register
   assign inv_in = csr_wr_en ? csr_wr_data : inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= INV_W'(ONE_Q);
      end else begin
         inv_ff <= inv_in;
      end
   end

   // Request unpacking
   assign node_x = req_tdata[NODE_W-1:0];
   assign node_y = req_tdata[2*NODE_W-1:NODE_W];
   assign pos_x  = req_tdata[2*NODE_W+POS_W-1:2*NODE_W];
   assign pos_y  = req_tdata[2*NODE_W+2*POS_W-1:2*NODE_W+POS_W];

   // Stage valids and enables
   bwg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stage_en   (stage_en)
   );

   // Kernel per axis
   bwg_axis u_axis_x (
      .clock       (clock),
      .stage_en    (stage_en[AXIS_STAGES-1:0]),
      .node        (node_x),
      .pos         (pos_x),
      .inv_spacing (inv_ff),
      .res         (res_x)
   );

   bwg_axis u_axis_y (
      .clock       (clock),
      .stage_en    (stage_en[AXIS_STAGES-1:0]),
      .node        (node_y),
      .pos         (pos_y),
      .inv_spacing (inv_ff),
      .res         (res_y)
   );

   // Cross-axis products and output register
   bwg_grad u_grad (
      .clock       (clock),
      .stage_en    (stage_en[STAGES-1:AXIS_STAGES]),
      .inv_spacing (inv_ff),
      .res_x       (res_x),
      .res_y       (res_y),
      .grad_x      (grad_x),
      .grad_y      (grad_y)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_FIELDS_W)'(0), grad_y, grad_x};

endmodule

[verif/bspline_weight_gradient_2d_tb.sv]
`timescale 1ns / 1ps

module bspline_weight_gradient_2d_tb;

   import bwg_pkg::*;

   localparam int Q               = ONE_Q;
   localparam int N_ROWS          = 23;
   localparam int N_PHASES        = 8;
   localparam int PHASE_REQUESTS  = 150;
   localparam int HOLD_OFF_PHASE  = 2;
   localparam int HOLD_OFF_AT     = 50;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int STEADY_PHASE    = 5;
   localparam int DRAIN_CYCLES    = 2 * STAGES;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Spacing plan markers for randomly chosen settings
   localparam int SPACING_ANY  = -1;
   localparam int SPACING_NEAR = -2;

   localparam longint GRAD_MAX = 64'sd16777215;
   localparam longint GRAD_MIN = -64'sd16777216;

   // One request, node_x in the lowest bits
   typedef struct packed {
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_x;
      logic [NODE_W-1:0]       node_y;
      logic [NODE_W-1:0]       node_x;
   } request_type;

   // One result, grad_x in the lowest bits
   typedef struct packed {
      logic signed [OUT_W-1:0] grad_y;
      logic signed [OUT_W-1:0] grad_x;
   } grad_pair_type;

   // Directed row: spacing, request, and a typed result where it is obvious
   typedef struct packed {
      logic [INV_W-1:0]        inv;
      logic [NODE_W-1:0]       node_x;
      logic [NODE_W-1:0]       node_y;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    typed_result;
      logic signed [OUT_W-1:0] grad_x;
      logic signed [OUT_W-1:0] grad_y;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [INV_W-1:0]      csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // node_x, node_y, pos_x, pos_y
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // grad_x, grad_y

   // Predictor state and scoreboard
   logic [INV_W-1:0] inv_model;
   grad_pair_type    offered_grads[$];
   grad_pair_type    grads_due[$];
   int               mismatches;
   int               requests_taken;
   int               results_checked;
   int               quiet_cycles;
   int               settings_used;
   bit               steady;
   bit               hold_off_due;
   bit               hold_off_done;

   stim_row_type stim_rows [N_ROWS] = '{
      // node on the particle: zero slope
      '{24'h010000, 10'd0, 10'd0, 0, 0, 1'b1, 25'sd0, 25'sd0},
      '{24'h010000, 10'd5, 10'd5, 5*Q, 5*Q, 1'b1, 25'sd0, 25'sd0},
      // far node, exactly at +/-2 and beyond
      '{24'h010000, 10'd0, 10'd0, 2*Q, 0, 1'b1, 25'sd0, 25'sd0},
      '{24'h010000, 10'd0, 10'd0, -2*Q, 0, 1'b1, 25'sd0, 25'sd0},
      '{24'h010000, 10'd0, 10'd0, 32'h80000000, 32'h7FFFFFFF, 1'b1, 25'sd0, 25'sd0},
      '{24'h010000, 10'd1023, 10'd1023, 0, 0, 1'b1, 25'sd0, 25'sd0},
      // inner and outer segments, both signs, boundaries
      '{24'h010000, 10'd1023, 10'd1023, 1023*Q+Q/2, 1023*Q+Q/4, 1'b0, 25'sd0, 25'sd0},
      '{24'h010000, 10'd3, 10'd3, 3*Q+Q/2, 3*Q, 1'b0, 25'sd0, 25'sd0},
      '{24'h010000, 10'd3, 10'd3, 3*Q-Q/2, 3*Q, 1'b0, 25'sd0, 25'sd0},
      '{24'h010000, 10'd0, 10'd0, Q, 0, 1'b0, 25'sd0, 25'sd0},
      '{24'h010000, 10'd0, 10'd0, -Q, 0, 1'b0, 25'sd0, 25'sd0},
      '{24'h010000, 10'd0, 10'd7, 2*Q-1, 5*Q+1, 1'b0, 25'sd0, 25'sd0},
      '{24'h010000, 10'd4, 10'd4, 4*Q+3*Q/2, 4*Q-3*Q/2, 1'b0, 25'sd0, 25'sd0},
      '{24'h010000, 10'd9, 10'd2, 9*Q+Q/4, 2*Q+3*Q/4, 1'b0, 25'sd0, 25'sd0},
      '{24'h010000, 10'd0, 10'd0, Q-1, -(Q-1), 1'b0, 25'sd0, 25'sd0},
      // largest spacing register: slope peak near |d| = 2/3
      '{24'hFFFFFF, 10'd0, 10'd0, 171, -171, 1'b0, 25'sd0, 25'sd0},
      '{24'hFFFFFF, 10'd0, 10'd0, 1, 0, 1'b0, 25'sd0, 25'sd0},
      '{24'hFFFFFF, 10'd0, 10'd0, 32'h7FFFFFFF, 32'h80000000, 1'b1, 25'sd0, 25'sd0},
      // smallest spacing register: extreme positions land within half a cell
      '{24'h000001, 10'd0, 10'd0, 32'h7FFFFFFF, 32'h80000000, 1'b0, 25'sd0, 25'sd0},
      '{24'h000001, 10'd1, 10'd0, 32'h7FFFFFFF, 0, 1'b0, 25'sd0, 25'sd0},
      // zero spacing register: every gradient vanishes
      '{24'h000000, 10'd0, 10'd0, 12345, -999, 1'b1, 25'sd0, 25'sd0},
      '{24'h000000, 10'd1, 10'd2, 32'h7FFFFFFF, 32'h80000000, 1'b1, 25'sd0, 25'sd0},
      '{24'h000000, 10'd1023, 10'd0, -1, 1, 1'b1, 25'sd0, 25'sd0}
   };

   int spacing_plan [N_PHASES] = '{
      32'h010000, 32'hFFFFFF, SPACING_ANY, 1, SPACING_NEAR, 32'h020000, SPACING_ANY, 32'h010000
   };

   bspline_weight_gradient_2d DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor(v / 6) for either sign
   function automatic longint floor_div6(longint v);
      if (v >= 0) begin
         return v / 6;
      end
      return -((-v + 5) / 6);
   endfunction

   // Cubic B-spline weight and its odd derivative at offset d (Q.16)
   function automatic void spline_axis(longint d, output longint w, output longint dw);
      longint a, a2, a3, b, b2, b3, n;
      a  = (d < 0) ? -d : d;
      w  = 0;
      dw = 0;
      if (a < 2 * Q) begin
         if (a < Q) begin
            a2 = (a * a) >>> FRAC_BITS;
            a3 = (a2 * a) >>> FRAC_BITS;
            n  = floor_div6(3 * a3 - 6 * a2 + 4 * Q);
            w  = (n < 0) ? 0 : n;
            dw = (3 * a2 - 4 * a) >>> 1;
         end else begin
            b  = 2 * Q - a;
            b2 = (b * b) >>> FRAC_BITS;
            b3 = (b2 * b) >>> FRAC_BITS;
            w  = floor_div6(b3);
            dw = -(b2 >>> 1);
         end
         if (d < 0) begin
            dw = -dw;
         end
      end
   endfunction

   // slope * inv * other-axis weight, floored at each step, saturated
   function automatic logic [OUT_W-1:0] gradient_term(longint slope, longint weight, longint inv);
      longint t, g;
      t = (slope * inv) >>> FRAC_BITS;
      g = (t * weight) >>> FRAC_BITS;
      if (g > GRAD_MAX) begin
         g = GRAD_MAX;
      end
      if (g < GRAD_MIN) begin
         g = GRAD_MIN;
      end
      return g[OUT_W-1:0];
   endfunction

   function automatic grad_pair_type predict_grads(request_type r, longint inv);
      grad_pair_type p;
      longint dx, dy, wx, dwx, wy, dwy;
      p = '0;
      if (r.node_x < GRID_SIZE && r.node_y < GRID_SIZE) begin
         dx = (longint'(r.pos_x) * inv - (longint'(r.node_x) <<< (2 * FRAC_BITS))) >>> FRAC_BITS;
         dy = (longint'(r.pos_y) * inv - (longint'(r.node_y) <<< (2 * FRAC_BITS))) >>> FRAC_BITS;
         spline_axis(dx, wx, dwx);
         spline_axis(dy, wy, dwy);
         p.grad_x = gradient_term(dwx, wy, inv);
         p.grad_y = gradient_term(dwy, wx, inv);
      end
      return p;
   endfunction

   // Pick a node and a position whose offset lands in or just past the kernel support
   function automatic logic [NODE_W+POS_W-1:0] aim_axis(longint inv);
      logic [NODE_W-1:0] node;
      longint d, p;
      node = ($urandom_range(3) == 0) ? NODE_W'($urandom_range(1023))
                                      : NODE_W'($urandom_range(15));
      d = longint'($urandom_range(9 * Q / 2)) - 9 * Q / 4;
      p = ((longint'(node) <<< (2 * FRAC_BITS)) + (d <<< FRAC_BITS)) / inv;
      if (p > 64'sd2147483647 || p < -64'sd2147483648) begin
         node = '0;
         p = (d <<< FRAC_BITS) / inv;
         if (p > 64'sd2147483647) begin
            p = 64'sd2147483647;
         end
         if (p < -64'sd2147483648) begin
            p = -64'sd2147483648;
         end
      end
      return {node, p[POS_W-1:0]};
   endfunction

   function automatic request_type random_request(longint inv);
      request_type r;
      logic [95:0] noise;
      if (inv == 0 || $urandom_range(99) < 20) begin
         noise = {$urandom, $urandom, $urandom};
         r = noise[REQ_FIELDS_W-1:0];
      end else begin
         {r.node_x, r.pos_x} = aim_axis(inv);
         {r.node_y, r.pos_y} = aim_axis(inv);
      end
      return r;
   endfunction

   // Offer one request, with random gaps outside the steady phase, and hold it until taken
   task automatic send_request(request_type r);
      while (!steady && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - REQ_FIELDS_W){1'b0}}, r};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Write the spacing register once the pipeline has drained
   task automatic set_spacing(logic [INV_W-1:0] value);
      req_tvalid <= 1'b0;
      while (grads_due.size() != 0 || offered_grads.size() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      inv_model = value;
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Request/result monitor, scoreboard and watchdog
   always @(posedge clock) begin
      grad_pair_type got, want;
      if (!reset) begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            grads_due.push_back(offered_grads.pop_front());
            requests_taken++;
            quiet_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            got = rsp_tdata[RSP_FIELDS_W-1:0];
            if (grads_due.size() == 0) begin
               $error("result with nothing outstanding: grad_x %0d grad_y %0d",
                      got.grad_x, got.grad_y);
               mismatches++;
            end else begin
               want = grads_due.pop_front();
               results_checked++;
               if (got.grad_x !== want.grad_x) begin
                  $error("grad_x: expected %0d, actual %0d", want.grad_x, got.grad_x);
                  mismatches++;
               end
               if (got.grad_y !== want.grad_y) begin
                  $error("grad_y: expected %0d, actual %0d", want.grad_y, got.grad_y);
                  mismatches++;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Result side: random back-pressure plus one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_tready <= steady || ($urandom_range(99) >= 20);
      end
   end

   // Stimulus
   initial begin
      request_type   r;
      grad_pair_type typed;
      int            setting;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      inv_model   = 24'h010000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      foreach (stim_rows[i]) begin
         if (stim_rows[i].inv != inv_model) begin
            set_spacing(stim_rows[i].inv);
         end
         r.node_x = stim_rows[i].node_x;
         r.node_y = stim_rows[i].node_y;
         r.pos_x  = stim_rows[i].pos_x;
         r.pos_y  = stim_rows[i].pos_y;
         typed.grad_x = stim_rows[i].grad_x;
         typed.grad_y = stim_rows[i].grad_y;
         offered_grads.push_back(stim_rows[i].typed_result ? typed
                                 : predict_grads(r, longint'(inv_model)));
         send_request(r);
      end

      // Random phases, one spacing setting each
      for (int ph = 0; ph < N_PHASES; ph++) begin
         setting = spacing_plan[ph];
         if (setting == SPACING_ANY) begin
            setting = $urandom_range(24'hFFFFFF, 1);
         end else if (setting == SPACING_NEAR) begin
            setting = $urandom_range(8 * Q, Q / 4);
         end
         set_spacing(setting[INV_W-1:0]);
         steady = (ph == STEADY_PHASE);
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            if (ph == HOLD_OFF_PHASE && k == HOLD_OFF_AT) begin
               hold_off_due = 1'b1;
            end
            r = random_request(longint'(inv_model));
            offered_grads.push_back(predict_grads(r, longint'(inv_model)));
            send_request(r);
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      // Drain
      while (grads_due.size() != 0 || offered_grads.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d directed) and %0d results over %0d spacing writes.",
               requests_taken, N_ROWS, results_checked, settings_used);
      $display("Receiver hold-off of %0d cycles with the sender still offering: %0s.",
               HOLD_OFF_CYCLES, hold_off_done ? "done" : "not reached");
      if (mismatches == 0 && grads_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
